@@ design/cpd_pkg.sv @@
`default_nettype none

package cpd_pkg;

   localparam int TicksWidth   = 32;
   localparam int ClockWidth   = 32;
   localparam int CaptureWidth = 32;
   localparam int AmpsWidth    = 7;

   // Capture bits at and above CaptureWidth are ignored
   localparam logic [TicksWidth-1:0] CaptureMask =
      TicksWidth'((65'd1 << CaptureWidth) - 65'd1);

   localparam logic [ClockWidth-1:0] ClockReset = 32'd1000000;

   localparam logic [9:0] FreqLowHz  = 10'd995;
   localparam logic [9:0] FreqHighHz = 10'd1005;
   localparam logic [6:0] PctScale   = 7'd100;
   localparam logic [6:0] DutyMinPct = 7'd3;
   localparam logic [6:0] DutyMaxPct = 7'd97;
   localparam logic [6:0] DutyKneePct = 7'd85;
   localparam logic [5:0] LowGain    = 6'd60;
   localparam logic [7:0] HighGain   = 8'd250;
   localparam logic [7:0] HighOffset = 8'd160;

   // 1005*P needs 42 bits, 100*W needs 39, 250*W needs 40
   localparam int FreqWidth = TicksWidth + 10;
   localparam int PctWidth  = TicksWidth + 7;
   localparam int RemWidth  = TicksWidth + 8;

   // One quotient bit per divider cell; amps never exceeds 82
   localparam int DivSteps = AmpsWidth;

   typedef struct packed {
      logic                  bad;
      logic [RemWidth-1:0]   rem;
      logic [TicksWidth-1:0] divisor;
      logic [AmpsWidth-1:0]  quot;
   } div_type;

endpackage

`default_nettype wire

@@ design/cpd_req_if.sv @@
`default_nettype none

interface cpd_req_if;
   logic                           valid;
   logic                           ready;
   logic [cpd_pkg::TicksWidth-1:0] period_ticks;
   logic [cpd_pkg::TicksWidth-1:0] pulse_ticks;

   modport source (output valid, output period_ticks, output pulse_ticks, input ready);
   modport sink (input valid, input period_ticks, input pulse_ticks, output ready);
endinterface

`default_nettype wire

@@ design/cpd_rsp_if.sv @@
`default_nettype none

interface cpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [cpd_pkg::AmpsWidth-1:0] amps;

   modport source (output valid, output status, output amps, input ready);
   modport sink (input valid, input status, input amps, output ready);
endinterface

`default_nettype wire

@@ design/cpd_front.sv @@
`default_nettype none

module cpd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [cpd_pkg::TicksWidth-1:0]  period_ticks,
   input  wire logic [cpd_pkg::TicksWidth-1:0]  pulse_ticks,
   input  wire logic [cpd_pkg::ClockWidth-1:0]  clock_hz,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output cpd_pkg::div_type                     out_data
);

   typedef struct packed {
      logic                                zero;
      logic [cpd_pkg::FreqWidth-1:0]       freq_lo;
      logic [cpd_pkg::FreqWidth-1:0]       freq_hi;
      logic [cpd_pkg::PctWidth-1:0]        pulse_pct;
      logic [cpd_pkg::PctWidth-1:0]        duty_min;
      logic [cpd_pkg::PctWidth-1:0]        duty_max;
      logic [cpd_pkg::PctWidth-1:0]        duty_knee;
      logic [cpd_pkg::TicksWidth-1:0]      period;
      logic [cpd_pkg::TicksWidth-1:0]      pulse;
   } prod_type;

   logic             a_valid_ff;
   prod_type         a_ff;
   prod_type         a_in;
   logic             a_advance;
   logic             b_valid_ff;
   cpd_pkg::div_type b_ff;
   cpd_pkg::div_type b_in;
   logic             b_advance;

   logic [cpd_pkg::TicksWidth-1:0] p;
   logic [cpd_pkg::TicksWidth-1:0] w;
   logic [cpd_pkg::FreqWidth-1:0]  clock_wide;
   logic                           freq_bad;
   logic                           duty_bad;
   logic                           below_knee;
   logic [cpd_pkg::RemWidth-1:0]   num_low;
   logic [cpd_pkg::RemWidth-1:0]   num_high;

   assign b_advance = !b_valid_ff || out_ready;
   assign a_advance = !a_valid_ff || b_advance;
   assign in_ready  = a_advance;

   // stage A: constant products
   always_comb begin
      p = period_ticks & cpd_pkg::CaptureMask;
      w = pulse_ticks & cpd_pkg::CaptureMask;
      a_in.zero      = (p == '0);
      a_in.freq_lo   = cpd_pkg::FreqWidth'(p) * cpd_pkg::FreqWidth'(cpd_pkg::FreqLowHz);
      a_in.freq_hi   = cpd_pkg::FreqWidth'(p) * cpd_pkg::FreqWidth'(cpd_pkg::FreqHighHz);
      a_in.pulse_pct = cpd_pkg::PctWidth'(w) * cpd_pkg::PctWidth'(cpd_pkg::PctScale);
      a_in.duty_min  = cpd_pkg::PctWidth'(p) * cpd_pkg::PctWidth'(cpd_pkg::DutyMinPct);
      a_in.duty_max  = cpd_pkg::PctWidth'(p) * cpd_pkg::PctWidth'(cpd_pkg::DutyMaxPct);
      a_in.duty_knee = cpd_pkg::PctWidth'(p) * cpd_pkg::PctWidth'(cpd_pkg::DutyKneePct);
      a_in.period    = p;
      a_in.pulse     = w;
   end

   // stage B: window checks and divider numerator
   always_comb begin
      clock_wide = cpd_pkg::FreqWidth'(clock_hz);
      freq_bad   = (clock_wide < a_ff.freq_lo) || (clock_wide > a_ff.freq_hi);
      duty_bad   = (a_ff.pulse_pct < a_ff.duty_min) || (a_ff.pulse_pct > a_ff.duty_max);
      below_knee = (a_ff.pulse_pct <= a_ff.duty_knee);
      num_low    = cpd_pkg::RemWidth'(a_ff.pulse) * cpd_pkg::RemWidth'(cpd_pkg::LowGain);
      // above the knee 250*W exceeds 160*P; never wraps when selected
      num_high   = cpd_pkg::RemWidth'(a_ff.pulse) * cpd_pkg::RemWidth'(cpd_pkg::HighGain)
                 - cpd_pkg::RemWidth'(a_ff.period) * cpd_pkg::RemWidth'(cpd_pkg::HighOffset);
      b_in.bad     = a_ff.zero || freq_bad || duty_bad;
      b_in.rem     = below_knee ? num_low : num_high;
      b_in.divisor = a_ff.period;
      b_in.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_advance) begin
            a_valid_ff <= in_valid;
         end
         if (b_advance) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance) begin
         a_ff <= a_in;
      end
      if (b_advance) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

@@ design/cpd_div_cell.sv @@
`default_nettype none

module cpd_div_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire cpd_pkg::div_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output cpd_pkg::div_type       out_data
);

   logic                         valid_ff;
   cpd_pkg::div_type             data_ff;
   cpd_pkg::div_type             data_in;
   logic                         advance;
   logic [cpd_pkg::RemWidth-1:0] trial;
   logic [cpd_pkg::RemWidth-1:0] rem_sub;
   logic                         fits;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // Compare against the divisor at the top quotient weight, then shift the
   // remainder up so every cell uses the same weight.
   always_comb begin
      trial   = {2'b00, in_data.divisor, 6'b000000};
      fits    = (in_data.rem >= trial);
      rem_sub = fits ? (in_data.rem - trial) : in_data.rem;
      data_in.bad     = in_data.bad;
      data_in.rem     = {rem_sub[cpd_pkg::RemWidth-2:0], 1'b0};
      data_in.divisor = in_data.divisor;
      data_in.quot    = {in_data.quot[cpd_pkg::AmpsWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ design/control_pilot_pwm_decoder.sv @@
// Control pilot PWM decoder.
// req channel: one transaction carries a captured pilot period and high-pulse
//   width, both in capture timer ticks.
// rsp channel: one transaction per request, in order: status (0 = PWM valid,
//   1 = no signal, frequency outside 995..1005 Hz or duty outside 3..97 %)
//   and the advertised current in amperes (0 on error).
// csr port: csr_write_enable/csr_write_data load the capture timer rate in Hz.
//   Write it only while no transaction is in flight.
// Pipeline: two check stages, then seven divider cells, one quotient bit per
//   cell.
// Throughput: one transaction per cycle while rsp.ready is high; each stage
//   holds one transaction and advances when the next stage is empty or moving.
// Stall: a stalled response holds in the last cell; earlier stages keep
//   filling, and req.ready drops only once every stage is occupied.
// Reset: all stages empty, timer rate back to 1000000 Hz.
`default_nettype none

module control_pilot_pwm_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cpd_req_if.sink                              req,
   cpd_rsp_if.source                            rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [cpd_pkg::ClockWidth-1:0]  csr_write_data
);

   logic [cpd_pkg::ClockWidth-1:0] clock_hz_ff;
   logic [cpd_pkg::DivSteps:0]     stage_valid;
   logic [cpd_pkg::DivSteps:0]     stage_ready;
   cpd_pkg::div_type               stage_data [cpd_pkg::DivSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= cpd_pkg::ClockReset;
      end else if (csr_write_enable) begin
         clock_hz_ff <= csr_write_data;
      end
   end

   cpd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .period_ticks (req.period_ticks),
      .pulse_ticks  (req.pulse_ticks),
      .clock_hz     (clock_hz_ff),
      .out_valid    (stage_valid[0]),
      .out_ready    (stage_ready[0]),
      .out_data     (stage_data[0])
   );

   for (genvar i = 0; i < cpd_pkg::DivSteps; i++) begin : g_cell
      cpd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   assign stage_ready[cpd_pkg::DivSteps] = rsp.ready;
   assign rsp.valid  = stage_valid[cpd_pkg::DivSteps];
   assign rsp.status = stage_data[cpd_pkg::DivSteps].bad;
   assign rsp.amps   = stage_data[cpd_pkg::DivSteps].bad ? '0
                                                         : stage_data[cpd_pkg::DivSteps].quot;

endmodule

`default_nettype wire
